>>> sv/tts_pkg.sv
// package for the thread table scheduler: payload types, codes and constants
// no dependencies
`default_nettype none
package tts_pkg;

    localparam int MaxThreadsDefault = 16;
    localparam int SjfCeiling = 100;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_CREATE = 2'd1;
    localparam logic [1:0] CMD_JOIN   = 2'd2;
    localparam logic [1:0] CMD_INIT   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSWITCH = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] TS_READY      = 2'd0;
    localparam logic [1:0] TS_RUNNING    = 2'd1;
    localparam logic [1:0] TS_TERMINATED = 2'd2;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_RR   = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;
    localparam logic [1:0] POL_SJF  = 2'd3;

    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_MAIN_ID   = 2'd1;
    localparam logic [1:0] REG_MAIN_LIFE = 2'd2;
    localparam logic [1:0] REG_MAIN_PRIO = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [7:0] thread_id;
        logic [14:0]       life_in;
        logic [7:0]        prio_in;
    } tts_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [7:0] from_id;
        logic signed [7:0] to_id;
    } tts_out_t;

    // one table entry
    typedef struct packed {
        logic signed [7:0]  id;
        logic signed [15:0] life;
        logic [7:0]         prio;
        logic [1:0]         st;
    } tts_entry_t;

endpackage
`default_nettype wire

>>> sv/tts_table.sv
// thread table storage: one read port, one write port, registered read data
// depends on tts_pkg
`default_nettype none
module tts_table
    import tts_pkg::*;
#(
    parameter int MAX_THREADS = MaxThreadsDefault
)
(
    input  wire logic                           clk,
    input  wire logic [$clog2(MAX_THREADS)-1:0] rd_addr,
    output tts_entry_t                          rd_data,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(MAX_THREADS)-1:0] wr_addr,
    input  wire tts_entry_t                     wr_data
);
    tts_entry_t mem [MAX_THREADS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> sv/thread_table_scheduler_core.sv
// Thread table scheduler. Each beat is handled alone; in_stall stays high from
// the accepted input beat until its result beat has been taken. Each table read
// takes an address state (S_RD) and a registered-data state. Init and create go
// straight to the result; join walks the table (find, then shift down); a fifo or
// round robin tick makes one ring search pass; a priority or shortest-job tick
// makes a best-value pass then a first-match pass. The single read port of
// tts_table is shared by all passes and sets the pace.
// depends on tts_pkg and tts_table
`default_nettype none
module thread_table_scheduler_core
    import tts_pkg::*;
#(
    parameter int MAX_THREADS = MaxThreadsDefault
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire tts_in_t    in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output tts_out_t        out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int AW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_THREADS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // issue read at idx_reg
    localparam logic [3:0] S_EV    = 4'd2;  // evaluate read data
    localparam logic [3:0] S_CUR   = 4'd3;  // current entry read back
    localparam logic [3:0] S_FIN   = 4'd4;  // finish: join bookkeeping, or read target
    localparam logic [3:0] S_OUT   = 4'd5;
    localparam logic [3:0] S_TGT   = 4'd6;  // target entry read back
    localparam logic [3:0] S_RRCUR = 4'd7;  // rr: current entry read back
    localparam logic [3:0] S_RRTGT = 4'd8;  // rr: target entry read back

    // phases of a pass
    localparam logic [2:0] P_JFIND = 3'd0;
    localparam logic [2:0] P_JMOVE = 3'd1;
    localparam logic [2:0] P_RING  = 3'd2;
    localparam logic [2:0] P_BEST  = 3'd3;
    localparam logic [2:0] P_MATCH = 3'd4;
    localparam logic [2:0] P_CUR   = 3'd5;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  policy_reg;
    logic signed [7:0]  main_id_reg;
    logic signed [15:0] main_life_reg;
    logic [7:0]  main_prio_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] idx_reg, idx_next;     // walking position
    logic [AW-1:0] pos_reg, pos_next;     // ring p / join k
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] live_reg, live_next;
    logic signed [16:0] best_reg, best_next;
    logic [AW-1:0] tgt_reg, tgt_next;
    logic signed [7:0] cid_reg, cid_next; // id of current entry
    logic        cmain_reg, cmain_next;   // current entry is main
    tts_in_t     item_reg, item_next;
    tts_out_t    res_reg, res_next;
    logic        ov_reg, ov_next;

    logic [AW-1:0] rd_addr;
    tts_entry_t    rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    tts_entry_t    wr_data;

    tts_table #(.MAX_THREADS(MAX_THREADS)) u_table (
        .clk    (clk),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = res_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_FIFO;
            main_id_reg   <= -8'sd1;
            main_life_reg <= 16'sd32767;
            main_prio_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_POLICY:    policy_reg    <= cfg_data[1:0];
                REG_MAIN_ID:   main_id_reg   <= cfg_data[7:0];
                REG_MAIN_LIFE: main_life_reg <= cfg_data;
                REG_MAIN_PRIO: main_prio_reg <= cfg_data[7:0];
                default:       policy_reg    <= policy_reg;
            endcase
        end
    end

    logic          rd_term;
    logic [AW-1:0] last_slot;
    assign last_slot = AW'(cnt_reg - 1'b1);
    assign rd_term   = rd_data.st == TS_TERMINATED;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        step_next = step_reg;
        live_next = live_reg;
        best_next = best_reg;
        tgt_next = tgt_reg;
        cid_next = cid_reg;
        cmain_next = cmain_reg;
        item_next = item_reg;
        res_next = res_reg;
        ov_next = ov_reg;
        rd_addr = idx_reg;
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    item_next = in_data;
                    res_next = '{status: ST_OK, from_id: 8'sd0, to_id: 8'sd0};
                    case (in_data.cmd)
                        CMD_INIT:
                        begin
                            wr_en = 1'b1;
                            wr_addr = '0;
                            wr_data = '{id: main_id_reg, life: main_life_reg,
                                        prio: main_prio_reg, st: TS_RUNNING};
                            cnt_next = CW'(1);
                            cur_next = '0;
                            res_next.to_id = main_id_reg;
                            state_next = S_OUT;
                        end
                        CMD_CREATE:
                        begin
                            if (cnt_reg >= MaxCnt)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                wr_addr = AW'(cnt_reg);
                                wr_data = '{id: in_data.thread_id,
                                            life: {1'b0, in_data.life_in},
                                            prio: in_data.prio_in, st: TS_READY};
                                cnt_next = cnt_reg + 1'b1;
                                res_next.to_id = in_data.thread_id;
                            end
                            state_next = S_OUT;
                        end
                        CMD_JOIN:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = ST_NOTFOUND;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                idx_next = '0;
                                phase_next = P_JFIND;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg <= CW'(1))
                            begin
                                res_next.status = ST_NOSWITCH;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                if (CW'(cur_reg) >= cnt_reg)
                                begin
                                    cur_next = '0;
                                end
                                state_next = S_CUR;
                                phase_next = P_CUR;
                                idx_next = (CW'(cur_reg) >= cnt_reg) ? '0 : cur_reg;
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end

            S_RD:
            begin
                rd_addr = idx_reg;
                state_next = (phase_reg == P_CUR) ? S_CUR : S_EV;
            end

            S_CUR:
            begin
                // current entry: apply the pre-search update (none for round robin)
                cid_next = rd_data.id;
                cmain_next = rd_data.id == main_id_reg;
                wr_addr = cur_reg;
                wr_data = rd_data;
                live_next = '0;
                step_next = '0;
                pos_next = cur_reg;
                idx_next = '0;
                case (policy_reg)
                    POL_FIFO, POL_SJF:
                    begin
                        if (rd_data.id != main_id_reg)
                        begin
                            wr_en = 1'b1;
                            wr_data.life = '0;
                            wr_data.st = TS_TERMINATED;
                        end
                    end
                    POL_PRIO:
                    begin
                        wr_en = 1'b1;
                        if (rd_data.life != -16'sd32768)
                        begin
                            wr_data.life = rd_data.life - 16'sd1;
                        end
                        if (rd_data.id != main_id_reg && wr_data.life == 16'sd0)
                        begin
                            wr_data.st = TS_TERMINATED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (policy_reg == POL_FIFO || policy_reg == POL_RR)
                begin
                    phase_next = P_RING;
                    // first ring step from p = cur, walker and current coincide
                    if (cur_reg == last_slot && rd_data.id == main_id_reg)
                    begin
                        res_next.status = ST_NOSWITCH;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next = (cur_reg == last_slot) ? '0 : cur_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    phase_next = P_BEST;
                    best_next = (policy_reg == POL_PRIO) ? -17'sd1 : 17'(SjfCeiling);
                    state_next = S_RD;
                end
            end

            S_EV:
            begin
                case (phase_reg)
                    P_JFIND:
                    begin
                        if (rd_data.id == item_reg.thread_id && rd_term)
                        begin
                            pos_next = idx_reg;
                            if (idx_reg == last_slot)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                                phase_next = P_JMOVE;
                                state_next = S_RD;
                            end
                        end
                        else if (idx_reg == last_slot)
                        begin
                            res_next.status = ST_NOTFOUND;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    P_JMOVE:
                    begin
                        // shift entry down by one
                        wr_en = 1'b1;
                        wr_addr = idx_reg - 1'b1;
                        wr_data = rd_data;
                        if (idx_reg == last_slot)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    P_RING:
                    begin
                        step_next = step_reg + 1'b1;
                        if (rd_data.life > 16'sd0)
                        begin
                            tgt_next = idx_reg;
                            state_next = S_FIN;
                        end
                        else if (step_reg + 1'b1 >= cnt_reg)
                        begin
                            res_next.status = ST_NOSWITCH;
                            state_next = S_OUT;
                        end
                        else if (idx_reg == last_slot &&
                                 ((policy_reg == POL_FIFO && rd_data.id == main_id_reg) ||
                                  (policy_reg == POL_RR && cmain_reg)))
                        begin
                            res_next.status = ST_NOSWITCH;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next = (idx_reg == last_slot) ? '0 : idx_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    P_BEST:
                    begin
                        if (!rd_term)
                        begin
                            live_next = live_reg + 1'b1;
                            if (policy_reg == POL_PRIO &&
                                $signed({9'd0, rd_data.prio}) > best_reg)
                            begin
                                best_next = $signed({9'd0, rd_data.prio});
                            end
                            if (policy_reg == POL_SJF &&
                                17'(rd_data.life) < best_reg)
                            begin
                                best_next = 17'(rd_data.life);
                            end
                        end
                        if (idx_reg == last_slot)
                        begin
                            idx_next = '0;
                            if (live_next == CW'(1) && cmain_reg)
                            begin
                                res_next.status = ST_NOSWITCH;
                                state_next = S_OUT;
                            end
                            else if (policy_reg == POL_SJF &&
                                     best_next == 17'(SjfCeiling))
                            begin
                                tgt_next = '0;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                phase_next = P_MATCH;
                                state_next = S_RD;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        // first live entry holding the best value
                        if (!rd_term &&
                            ((policy_reg == POL_PRIO &&
                              $signed({9'd0, rd_data.prio}) == best_reg) ||
                             (policy_reg == POL_SJF && 17'(rd_data.life) == best_reg)))
                        begin
                            tgt_next = idx_reg;
                            state_next = S_FIN;
                        end
                        else if (idx_reg == last_slot)
                        begin
                            res_next.status = ST_NOSWITCH;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                endcase
            end

            S_FIN:
            begin
                if (phase_reg == P_JFIND || phase_reg == P_JMOVE)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    cur_next = (pos_reg < cur_reg) ? cur_reg - 1'b1 : cur_reg;
                    if (CW'(cur_next) >= cnt_next)
                    begin
                        cur_next = '0;
                    end
                    res_next.to_id = item_reg.thread_id;
                    state_next = S_OUT;
                end
                else
                begin
                    rd_addr = tgt_reg;
                    state_next = S_TGT;
                end
            end

            S_TGT:
            begin
                // round robin charges the current entry only on a switch
                if (policy_reg == POL_RR)
                begin
                    wr_en = 1'b1;
                    wr_addr = cur_reg;
                    phase_next = P_CUR;
                end
                wr_data = rd_data;
                if (policy_reg != POL_RR)
                begin
                    wr_en = 1'b1;
                    wr_addr = tgt_reg;
                    wr_data.st = TS_RUNNING;
                    res_next.from_id = cid_reg;
                    res_next.to_id = rd_data.id;
                    cur_next = tgt_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    // rr: tgt read now, cur read next
                    res_next.to_id = rd_data.id;
                    res_next.from_id = cid_reg;
                    wr_en = 1'b0;
                    rd_addr = cur_reg;
                    phase_next = P_JFIND;
                    state_next = S_RRCUR;
                end
            end

            S_RRCUR:
            begin
                // rr: decrement current then mark target running
                wr_en = 1'b1;
                wr_addr = cur_reg;
                wr_data = rd_data;
                if (rd_data.life != -16'sd32768)
                begin
                    wr_data.life = rd_data.life - 16'sd1;
                end
                if (!cmain_reg && wr_data.life == 16'sd0)
                begin
                    wr_data.st = TS_TERMINATED;
                end
                if (tgt_reg == cur_reg)
                begin
                    wr_data.st = TS_RUNNING;
                    cur_next = tgt_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    rd_addr = tgt_reg;
                    state_next = S_RRTGT;
                end
            end

            S_RRTGT:
            begin
                wr_en = 1'b1;
                wr_addr = tgt_reg;
                wr_data = rd_data;
                wr_data.st = TS_RUNNING;
                cur_next = tgt_reg;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                ov_next = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and work registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= P_JFIND;
            cnt_reg   <= '0;
            cur_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            cur_reg   <= cur_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        step_reg  <= step_next;
        live_reg  <= live_next;
        best_reg  <= best_next;
        tgt_reg   <= tgt_next;
        cid_reg   <= cid_next;
        cmain_reg <= cmain_next;
        item_reg  <= item_next;
        res_reg   <= res_next;
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MaxCnt)
        else $error("entry count beyond table size");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(res_reg))
        else $error("result changed while stalled");
    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input open while busy");
endmodule
`default_nettype wire
